// ===== rtl/msd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

  localparam int unsigned DotBits     = 12;
  localparam int unsigned CharGapBits = 14;
  localparam int unsigned WordGapBits = 15;
  localparam int unsigned CharBits    = 7;
  localparam int unsigned PatBits     = 5;
  localparam int unsigned CntBits     = 3;
  localparam int unsigned MaxElements = 5;

  localparam logic [DotBits-1:0]  DotTimingReset = 12'd8;
  localparam logic [CharBits-1:0] CharSpace      = 7'h20;
  localparam logic [CharBits-1:0] CharUnknown    = 7'h3f;

  // One queued result: the character and its end-of-item flag.
  typedef struct packed {
    logic                last;
    logic [CharBits-1:0] code;
  } result_t;

  // Map a collected symbol to its ASCII character; dash = 1, oldest element in the
  // highest used bit.
  function automatic logic [CharBits-1:0] symbol_char(
    input logic               overflow,
    input logic [CntBits-1:0] count,
    input logic [PatBits-1:0] pattern
  );
    logic [CharBits-1:0] ch;
    ch = CharUnknown;
    if (overflow) begin
      ch = CharUnknown;
    end else if (count == '0) begin
      ch = CharSpace;
    end else begin
      unique case ({count, pattern})
        {3'd1, 5'b00000}: ch = 7'h65; // e
        {3'd1, 5'b00001}: ch = 7'h74; // t
        {3'd2, 5'b00001}: ch = 7'h61; // a
        {3'd2, 5'b00000}: ch = 7'h69; // i
        {3'd2, 5'b00011}: ch = 7'h6d; // m
        {3'd2, 5'b00010}: ch = 7'h6e; // n
        {3'd3, 5'b00100}: ch = 7'h64; // d
        {3'd3, 5'b00110}: ch = 7'h67; // g
        {3'd3, 5'b00101}: ch = 7'h6b; // k
        {3'd3, 5'b00111}: ch = 7'h6f; // o
        {3'd3, 5'b00010}: ch = 7'h72; // r
        {3'd3, 5'b00000}: ch = 7'h73; // s
        {3'd3, 5'b00001}: ch = 7'h75; // u
        {3'd3, 5'b00011}: ch = 7'h77; // w
        {3'd4, 5'b01000}: ch = 7'h62; // b
        {3'd4, 5'b01010}: ch = 7'h63; // c
        {3'd4, 5'b00010}: ch = 7'h66; // f
        {3'd4, 5'b00000}: ch = 7'h68; // h
        {3'd4, 5'b00111}: ch = 7'h6a; // j
        {3'd4, 5'b00100}: ch = 7'h6c; // l
        {3'd4, 5'b00110}: ch = 7'h70; // p
        {3'd4, 5'b01101}: ch = 7'h71; // q
        {3'd4, 5'b00001}: ch = 7'h76; // v
        {3'd4, 5'b01001}: ch = 7'h78; // x
        {3'd4, 5'b01011}: ch = 7'h79; // y
        {3'd4, 5'b01100}: ch = 7'h7a; // z
        {3'd5, 5'b01111}: ch = 7'h31; // 1
        {3'd5, 5'b00111}: ch = 7'h32; // 2
        {3'd5, 5'b00011}: ch = 7'h33; // 3
        {3'd5, 5'b00001}: ch = 7'h34; // 4
        {3'd5, 5'b00000}: ch = 7'h35; // 5
        {3'd5, 5'b10000}: ch = 7'h36; // 6
        {3'd5, 5'b11000}: ch = 7'h37; // 7
        {3'd5, 5'b11100}: ch = 7'h38; // 8
        {3'd5, 5'b11110}: ch = 7'h39; // 9
        {3'd5, 5'b11111}: ch = 7'h30; // 0
        default:          ch = CharUnknown;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/morse_sample_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Morse decoder for a keyed sample stream. Each input item is one key sample
// (1 = key down); tlast marks the last sample of a frame. Ended on-runs become
// dots or dashes against dot_timing, off-runs of at least 3x or 7x dot_timing emit the
// collected character (plus a space for a word gap) as lower-case ASCII, and a
// frame end flushes a pending symbol. Each sample's results, zero to two, go
// into a four-entry output queue; the input accepts an item in every cycle in
// which the queue has room for two results, so samples stream at one per cycle
// and throughput is bounded only by the output side draining one result per
// cycle. Write dot_timing only while idle.
module morse_sample_decoder_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_wdata_i,   // dot_timing
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [0] sample, [7:1] zero
  input  wire logic        s_axis_tlast,  // frame_end
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,  // [6:0] char_code, [7] zero
  output      logic        m_axis_tlast   // last_of_run
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration and derived gap thresholds
  logic [msd_pkg::DotBits-1:0]     dot_q;
  logic [msd_pkg::CharGapBits-1:0] char_gap_q, char_gap_d;
  logic [msd_pkg::WordGapBits-1:0] word_gap_q, word_gap_d;

  always_comb begin
    char_gap_d = ({2'b00, cfg_wdata_i} << 1) + {2'b00, cfg_wdata_i};
    word_gap_d = ({3'b000, cfg_wdata_i} << 3) - {3'b000, cfg_wdata_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q      <= msd_pkg::DotTimingReset;
      char_gap_q <= msd_pkg::CharGapBits'(msd_pkg::DotTimingReset * 3);
      word_gap_q <= msd_pkg::WordGapBits'(msd_pkg::DotTimingReset * 7);
    end else if (cfg_we_i) begin
      dot_q      <= cfg_wdata_i;
      char_gap_q <= char_gap_d;
      word_gap_q <= word_gap_d;
    end
  end

  // Decoder state
  logic                          fresh_q, fresh_d;
  logic                          level_q, level_d;
  logic [COUNT_BITS-1:0]         len_q, len_d;
  logic [msd_pkg::PatBits-1:0]   pat_q, pat_d;
  logic [msd_pkg::CntBits-1:0]   cnt_q, cnt_d;
  logic                          ovf_q, ovf_d;

  // Symbol after an ended on-run is appended
  logic [msd_pkg::PatBits-1:0]   pat_mid;
  logic [msd_pkg::CntBits-1:0]   cnt_mid;
  logic                          ovf_mid;
  logic [msd_pkg::CharBits-1:0]  sym_char;

  logic                          in_fire, out_fire;
  logic                          sample;
  logic [1:0]                    push_n;
  logic                          is_dash, at_word, at_char;

  assign sample   = s_axis_tdata[0];
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign is_dash  = len_q > COUNT_BITS'(dot_q);
  assign at_word  = len_q >= COUNT_BITS'(word_gap_q);
  assign at_char  = len_q >= COUNT_BITS'(char_gap_q);

  always_comb begin
    pat_mid = pat_q;
    cnt_mid = cnt_q;
    ovf_mid = ovf_q;
    if (!fresh_q && (sample != level_q) && level_q) begin
      if (cnt_q >= msd_pkg::CntBits'(msd_pkg::MaxElements)) begin
        ovf_mid = 1'b1;
      end else begin
        pat_mid = {pat_q[msd_pkg::PatBits-2:0], is_dash};
        cnt_mid = cnt_q + 1'b1;
      end
    end
  end

  assign sym_char = msd_pkg::symbol_char(ovf_mid, cnt_mid, pat_mid);

  always_comb begin
    fresh_d = fresh_q;
    level_d = level_q;
    len_d   = len_q;
    pat_d   = pat_mid;
    cnt_d   = cnt_mid;
    ovf_d   = ovf_mid;
    push_n  = 2'd0;

    if (fresh_q) begin
      fresh_d = 1'b0;
      level_d = sample;
      len_d   = COUNT_BITS'(1);
      pat_d   = '0;
      cnt_d   = '0;
      ovf_d   = 1'b0;
    end else if (sample != level_q) begin
      if (!level_q) begin
        if (at_word) begin
          push_n = 2'd2;
          pat_d  = '0;
          cnt_d  = '0;
          ovf_d  = 1'b0;
        end else if (at_char) begin
          push_n = 2'd1;
          pat_d  = '0;
          cnt_d  = '0;
          ovf_d  = 1'b0;
        end
      end
      level_d = sample;
      len_d   = COUNT_BITS'(1);
    end else if (len_q != '1) begin
      len_d = len_q + 1'b1;
    end

    // Flush a pending symbol at frame end; a gap that emitted has cleared it
    if (s_axis_tlast) begin
      if (!fresh_q && (cnt_mid != '0 || ovf_mid) && push_n == 2'd0) begin
        push_n = 2'd1;
      end
      pat_d   = '0;
      cnt_d   = '0;
      ovf_d   = 1'b0;
      fresh_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      level_q <= 1'b0;
      len_q   <= COUNT_BITS'(1);
      pat_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (in_fire) begin
      fresh_q <= fresh_d;
      level_q <= level_d;
      len_q   <= len_d;
      pat_q   <= pat_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  // Output queue
  msd_pkg::result_t      q_mem [QDepth];
  logic [QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]      q_cnt_q, q_cnt_d;
  logic [1:0]            push_eff;
  msd_pkg::result_t      res0, res1;

  assign push_eff = in_fire ? push_n : 2'd0;

  always_comb begin
    res0.code = sym_char;
    res0.last = (push_n == 2'd1);
    res1.code = msd_pkg::CharSpace;
    res1.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_eff != 2'd0) begin
      q_mem[wr_ptr_q] <= res0;
    end
    if (push_eff == 2'd2) begin
      q_mem[wr_ptr_q + 1'b1] <= res1;
    end
  end

  assign out_fire = m_axis_tvalid & m_axis_tready;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_eff);
    rd_ptr_d = rd_ptr_q + QPtrW'(out_fire);
    q_cnt_d  = q_cnt_q + QCntW'(push_eff) - QCntW'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      q_cnt_q  <= q_cnt_d;
    end
  end

  // Take an item only with room for two results
  assign s_axis_tready = q_cnt_q <= QCntW'(QDepth - 2);
  assign m_axis_tvalid = q_cnt_q != '0;
  assign m_axis_tdata  = {1'b0, q_mem[rd_ptr_q].code};
  assign m_axis_tlast  = q_mem[rd_ptr_q].last;

endmodule

`default_nettype wire
